@@ design/smc_pkg.sv @@
// servo step motion controller package
// request/result payload types, configuration type, request and status codes
// no dependencies
package smc_pkg;

	localparam logic [2:0] REQ_TICK       = 3'd0;
	localparam logic [2:0] REQ_BEGIN      = 3'd1;
	localparam logic [2:0] REQ_BEGIN_SAFE = 3'd2;
	localparam logic [2:0] REQ_CLEAR      = 3'd3;
	localparam logic [2:0] REQ_INIT       = 3'd4;

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_STEPPING = 2'd1;
	localparam logic [1:0] ST_REACHED  = 2'd2;
	localparam logic [1:0] ST_STUCK    = 2'd3;

	localparam logic CFG_STEP_SIZE     = 1'b0;
	localparam logic CFG_STEP_INTERVAL = 1'b1;

	localparam logic [7:0]  DEFAULT_STEP_SIZE     = 8'd2;
	localparam logic [31:0] DEFAULT_STEP_INTERVAL = 32'd20;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] angle_in;
		logic [31:0] motion_timeout;
		logic [31:0] now_time;
	} req_t;

	typedef struct packed {
		logic [15:0] angle_out;
		logic [1:0]  status;
		logic        accepted;
		logic        stuck_flag;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  step_size;
		logic [31:0] step_interval;
	} cfg_t;

endpackage

@@ design/smc_cfg.sv @@
// servo step motion controller configuration registers
// step size and step interval, written through the configuration channel
// depends on smc_pkg
module smc_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data,
	output smc_pkg::cfg_t cfg
);

	logic [7:0]  step_size_q;
	logic [31:0] step_interval_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q     <= smc_pkg::DEFAULT_STEP_SIZE;
			step_interval_q <= smc_pkg::DEFAULT_STEP_INTERVAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				smc_pkg::CFG_STEP_SIZE:     step_size_q     <= cfg_data[7:0];
				smc_pkg::CFG_STEP_INTERVAL: step_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.step_size     = step_size_q;
	assign cfg.step_interval = step_interval_q;

endmodule

@@ design/smc_core.sv @@
// servo step motion controller core
// input register, motion state and the single-pass request logic
// depends on smc_pkg
module smc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  smc_pkg::req_t req,
	input  smc_pkg::cfg_t cfg,
	input  logic          out_free,
	output logic          load,
	output smc_pkg::rsp_t res,
	output logic          busy
);

	smc_pkg::req_t req_s1;
	logic          valid_s1;

	logic [15:0] current_angle_q, target_angle_q, safe_angle_q;
	logic [31:0] step_start_q, motion_start_q, motion_limit_q;
	logic        moving_q, stuck_q;

	logic [15:0] current_angle_d, target_angle_d, safe_angle_d;
	logic [31:0] step_start_d, motion_start_d, motion_limit_d;
	logic        moving_d, stuck_d;

	logic [15:0] step, remaining, adv;
	logic [31:0] interval, motion_elapsed, step_elapsed;
	logic        up;
	logic [1:0]  status;
	logic        accepted;

	assign load      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign busy      = valid_s1;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	assign step = (cfg.step_size == 8'd0) ? {8'd0, smc_pkg::DEFAULT_STEP_SIZE}
		: {8'd0, cfg.step_size};
	assign interval = (cfg.step_interval == 32'd0) ? smc_pkg::DEFAULT_STEP_INTERVAL
		: cfg.step_interval;
	assign motion_elapsed = req_s1.now_time - motion_start_q;
	assign step_elapsed   = req_s1.now_time - step_start_q;
	assign up             = target_angle_q > current_angle_q;
	assign remaining      = up ? (target_angle_q - current_angle_q)
		: (current_angle_q - target_angle_q);
	assign adv            = (step < remaining) ? step : remaining;

	always_comb begin
		current_angle_d = current_angle_q;
		target_angle_d  = target_angle_q;
		safe_angle_d    = safe_angle_q;
		step_start_d    = step_start_q;
		motion_start_d  = motion_start_q;
		motion_limit_d  = motion_limit_q;
		moving_d        = moving_q;
		stuck_d         = stuck_q;
		accepted        = 1'b1;
		status          = smc_pkg::ST_IDLE;
		case (req_s1.req_type)
			smc_pkg::REQ_TICK: begin
				if (!moving_q) begin
					status = smc_pkg::ST_IDLE;
				end else if (motion_elapsed >= motion_limit_q) begin
					moving_d        = 1'b0;
					stuck_d         = 1'b1;
					current_angle_d = safe_angle_q;
					status          = smc_pkg::ST_STUCK;
				end else if (step_elapsed < interval) begin
					status = smc_pkg::ST_STEPPING;
				end else if (current_angle_q == target_angle_q) begin
					safe_angle_d = current_angle_q;
					moving_d     = 1'b0;
					status       = smc_pkg::ST_REACHED;
				end else begin
					safe_angle_d    = current_angle_q;
					current_angle_d = up ? (current_angle_q + adv) : (current_angle_q - adv);
					step_start_d    = req_s1.now_time;
					status          = smc_pkg::ST_STEPPING;
				end
			end
			smc_pkg::REQ_BEGIN, smc_pkg::REQ_BEGIN_SAFE: begin
				if (req_s1.req_type == smc_pkg::REQ_BEGIN_SAFE && stuck_q) begin
					accepted = 1'b0;
				end else begin
					target_angle_d = req_s1.angle_in;
					safe_angle_d   = current_angle_q;
					motion_start_d = req_s1.now_time;
					step_start_d   = req_s1.now_time;
					motion_limit_d = req_s1.motion_timeout;
					moving_d       = 1'b1;
					stuck_d        = 1'b0;
				end
				status = moving_d ? smc_pkg::ST_STEPPING : smc_pkg::ST_IDLE;
			end
			smc_pkg::REQ_CLEAR: begin
				moving_d = 1'b0;
				stuck_d  = 1'b0;
				status   = smc_pkg::ST_IDLE;
			end
			smc_pkg::REQ_INIT: begin
				current_angle_d = req_s1.angle_in;
				target_angle_d  = req_s1.angle_in;
				safe_angle_d    = req_s1.angle_in;
				step_start_d    = 32'd0;
				motion_start_d  = 32'd0;
				motion_limit_d  = 32'd0;
				moving_d        = 1'b0;
				stuck_d         = 1'b0;
				status          = smc_pkg::ST_IDLE;
			end
			default: begin
				status = moving_q ? smc_pkg::ST_STEPPING : smc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_angle_q <= 16'd0;
			target_angle_q  <= 16'd0;
			safe_angle_q    <= 16'd0;
			step_start_q    <= 32'd0;
			motion_start_q  <= 32'd0;
			motion_limit_q  <= 32'd0;
			moving_q        <= 1'b0;
			stuck_q         <= 1'b0;
		end else if (load) begin
			current_angle_q <= current_angle_d;
			target_angle_q  <= target_angle_d;
			safe_angle_q    <= safe_angle_d;
			step_start_q    <= step_start_d;
			motion_start_q  <= motion_start_d;
			motion_limit_q  <= motion_limit_d;
			moving_q        <= moving_d;
			stuck_q         <= stuck_d;
		end
	end

	assign res.angle_out  = current_angle_d;
	assign res.status     = status;
	assign res.accepted   = accepted;
	assign res.stuck_flag = stuck_d;

endmodule

@@ design/smc_out_reg.sv @@
// servo step motion controller result register
// holds one result until the receiver takes it
// depends on smc_pkg
module smc_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  smc_pkg::rsp_t res,
	output logic          out_free,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output smc_pkg::rsp_t rsp
);

	logic          valid_q;
	smc_pkg::rsp_t rsp_q;

	assign out_free = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

endmodule

@@ design/servo_step_motion_controller.sv @@
// servo step motion controller top level
// request channel in, result channel out, configuration write channel
// depends on smc_pkg, smc_cfg, smc_core, smc_out_reg
//
// usage:
// - request channel req_valid/req_stall/req carries one request per transfer
//   (tick, begin, begin_safe, clear flags, init home)
// - result channel rsp_valid/rsp_stall/rsp returns exactly one result per request
// - configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes step size
//   (index 0) and step interval (index 1); cfg_ready is always high, write only
//   while no request is in flight
// - flow: a request passes through the input register, then into the output register
//   once it is free, and its result can then transfer; one request per clock sustained
//   while results are taken, set by the single-pass state update
// - reset: motion state clears to zero, step size 2, step interval 20
// - stall: a stalled result holds in the output register; the input register
//   still takes one more request, after which req_stall rises until the
//   result is taken
module servo_step_motion_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  smc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output smc_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data
);

	smc_pkg::cfg_t cfg;
	smc_pkg::rsp_t res;
	logic          load;
	logic          out_free;
	logic          busy;

	smc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg       (cfg),
		.out_free  (out_free),
		.load      (load),
		.res       (res),
		.busy      (busy)
	);

	smc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.out_free  (out_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	a_stuck_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == smc_pkg::ST_STUCK |-> rsp.stuck_flag)
		else $error("stuck status without stuck flag");

	a_refused_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.accepted |-> rsp.stuck_flag)
		else $error("refused request while not stuck");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> busy && rsp_valid && rsp_stall)
		else $error("request stalled without a held result");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rsp_valid)
		else $error("loaded result not presented");
`endif

endmodule

@@ tb/smc_motion_checker.sv @@
`timescale 1ns / 1ps
// servo step motion controller checker: follows request, result and register write transfers,
// predicts each result from its own copy of the motion state and compares field by field
// depends on smc_pkg
module smc_motion_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  smc_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  smc_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data,
	output int            pending,
	output int            errors
);

	logic [7:0]    step_cfg;
	logic [31:0]   interval_cfg;
	logic [15:0]   pos;
	logic [15:0]   goal;
	logic [15:0]   fallback;
	logic [31:0]   step_t0;
	logic [31:0]   move_t0;
	logic [31:0]   budget;
	logic          in_motion;
	logic          is_stuck;
	smc_pkg::rsp_t commanded_q[$];

	function automatic void launch(input logic [15:0] aim, input logic [31:0] lim,
		input logic [31:0] stamp);
		goal      = aim;
		fallback  = pos;
		move_t0   = stamp;
		step_t0   = stamp;
		budget    = lim;
		in_motion = 1'b1;
		is_stuck  = 1'b0;
	endfunction

	function automatic smc_pkg::rsp_t follow_request(input smc_pkg::req_t r);
		smc_pkg::rsp_t o;
		logic [1:0]    st;
		logic          ok;
		logic [31:0]   ivl;
		logic [31:0]   elapsed;
		logic [31:0]   since;
		logic [15:0]   stride;
		logic [15:0]   remain;
		ok = 1'b1;
		st = smc_pkg::ST_IDLE;
		if (r.req_type == smc_pkg::REQ_TICK) begin
			ivl     = (interval_cfg != 0) ? interval_cfg : smc_pkg::DEFAULT_STEP_INTERVAL;
			stride  = {8'd0, (step_cfg != 0) ? step_cfg : smc_pkg::DEFAULT_STEP_SIZE};
			elapsed = r.now_time - move_t0;
			since   = r.now_time - step_t0;
			if (!in_motion) begin
				st = smc_pkg::ST_IDLE;
			end else if (elapsed >= budget) begin
				// budget spent: fall back to the angle saved at the start of the move or at the last step
				in_motion = 1'b0;
				is_stuck  = 1'b1;
				pos       = fallback;
				st        = smc_pkg::ST_STUCK;
			end else if (since < ivl) begin
				st = smc_pkg::ST_STEPPING;
			end else begin
				fallback = pos;
				if (pos == goal) begin
					in_motion = 1'b0;
					st        = smc_pkg::ST_REACHED;
				end else begin
					remain = (goal > pos) ? goal - pos : pos - goal;
					if (stride < remain)
						remain = stride;
					pos     = (goal > pos) ? pos + remain : pos - remain;
					step_t0 = r.now_time;
					st      = smc_pkg::ST_STEPPING;
				end
			end
		end else begin
			case (r.req_type)
			smc_pkg::REQ_BEGIN: begin
				launch(r.angle_in, r.motion_timeout, r.now_time);
			end
			smc_pkg::REQ_BEGIN_SAFE: begin
				if (is_stuck)
					ok = 1'b0;
				else
					launch(r.angle_in, r.motion_timeout, r.now_time);
			end
			smc_pkg::REQ_CLEAR: begin
				in_motion = 1'b0;
				is_stuck  = 1'b0;
			end
			smc_pkg::REQ_INIT: begin
				pos       = r.angle_in;
				goal      = r.angle_in;
				fallback  = r.angle_in;
				step_t0   = '0;
				move_t0   = '0;
				budget    = '0;
				in_motion = 1'b0;
				is_stuck  = 1'b0;
			end
			default: begin
			end
			endcase
			st = in_motion ? smc_pkg::ST_STEPPING : smc_pkg::ST_IDLE;
		end
		o.angle_out  = pos;
		o.status     = st;
		o.accepted   = ok;
		o.stuck_flag = is_stuck;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		smc_pkg::rsp_t want;
		if (!arst_n) begin
			step_cfg     = smc_pkg::DEFAULT_STEP_SIZE;
			interval_cfg = smc_pkg::DEFAULT_STEP_INTERVAL;
			pos          = '0;
			goal         = '0;
			fallback     = '0;
			step_t0      = '0;
			move_t0      = '0;
			budget       = '0;
			in_motion    = 1'b0;
			is_stuck     = 1'b0;
			errors       = 0;
			commanded_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == smc_pkg::CFG_STEP_SIZE)
					step_cfg = cfg_data[7:0];
				else
					interval_cfg = cfg_data;
			end
			if (rsp_valid && !rsp_stall) begin
				if (commanded_q.size() == 0) begin
					$error("result transfer with no request outstanding");
					errors++;
				end else begin
					want = commanded_q.pop_front();
					if (rsp.angle_out !== want.angle_out) begin
						$error("angle_out: expected %0d, actual %0d", want.angle_out,
							rsp.angle_out);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						errors++;
					end
					if (rsp.accepted !== want.accepted) begin
						$error("accepted: expected %0d, actual %0d", want.accepted,
							rsp.accepted);
						errors++;
					end
					if (rsp.stuck_flag !== want.stuck_flag) begin
						$error("stuck_flag: expected %0d, actual %0d", want.stuck_flag,
							rsp.stuck_flag);
						errors++;
					end
				end
			end
			if (req_valid && !req_stall)
				commanded_q.push_back(follow_request(req));
			pending <= commanded_q.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// servo step motion controller testbench top: clock, reset, request stimulus with bursts,
// result stall patterns, register phases and the verdict
// depends on smc_pkg, smc_motion_checker and the servo_step_motion_controller design
module tb;

	localparam int LIMIT_CYCLES = 300000;
	localparam int REQ_CODES    = 8;
	localparam int PHASE_ITEMS  = 330;
	localparam int PHASES       = 6;

	typedef enum logic [1:0] {HOLD_NONE, HOLD_LIGHT, HOLD_HEAVY, HOLD_PERIODIC} hold_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	smc_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	smc_pkg::rsp_t rsp;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_index = smc_pkg::CFG_STEP_SIZE;
	logic [31:0]   cfg_data  = '0;
	int            pending;
	int            errors;

	hold_t       hold_mode   = HOLD_NONE;
	int          hold_left   = 0;
	int          burst_left  = 1;
	int          sent        = 0;
	int          cycle_count = 0;
	logic [31:0] ms_now      = '0;
	logic [31:0] ivl_eff     = smc_pkg::DEFAULT_STEP_INTERVAL;

	servo_step_motion_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	smc_motion_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern, switching at random among none, light, heavy and periodic modes
	always @(posedge clk) begin
		if (hold_left == 0) begin
			hold_mode <= hold_t'($urandom_range(0, 3));
			hold_left <= $urandom_range(30, 300);
		end else begin
			hold_left <= hold_left - 1;
		end
		case (hold_mode)
		HOLD_NONE:  rsp_stall <= 1'b0;
		HOLD_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
		HOLD_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
		default:    rsp_stall <= hold_left[2];
		endcase
	end

	task automatic send(input logic [2:0] kind, input logic [15:0] ang,
		input logic [31:0] lim, input logic [31:0] stamp);
		smc_pkg::req_t r;
		int            gap;
		r.req_type       = kind;
		r.angle_in       = ang;
		r.motion_timeout = lim;
		r.now_time       = stamp;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (kind <= smc_pkg::REQ_INIT)
			sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off the sender until every outstanding result has been taken
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		drain();
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == smc_pkg::CFG_STEP_INTERVAL)
			ivl_eff = (val != 0) ? val : smc_pkg::DEFAULT_STEP_INTERVAL;
	endtask

	function automatic logic [31:0] pick_delta();
		logic [31:0] span;
		span = (ivl_eff > 2000) ? 32'd2000 : ivl_eff;
		case ($urandom_range(0, 9))
		0:       return '0;
		1:       return ivl_eff;
		2:       return ivl_eff - 1;
		3:       return $urandom;
		default: return $urandom_range(0, 2 * span);
		endcase
	endfunction

	task automatic drive_random(input int n);
		int          goal_count;
		int          ticks;
		logic [15:0] aim;
		logic [31:0] lim;
		logic [31:0] span;
		goal_count = sent + n;
		aim = 16'($urandom);
		while (sent < goal_count) begin
			span = (ivl_eff > 2000) ? 32'd2000 : ivl_eff;
			if ($urandom_range(0, 99) < 15) begin
				ms_now += pick_delta();
				send(3'($urandom_range(0, REQ_CODES - 1)), 16'($urandom), $urandom, ms_now);
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					aim = 16'($urandom);
					send(smc_pkg::REQ_INIT, aim, $urandom, $urandom);
				end
				if ($urandom_range(0, 9) == 0)
					aim = 16'($urandom);
				else
					aim = aim + 16'($urandom_range(0, 40)) - 16'd20;
				case ($urandom_range(0, 9))
				0:       lim = '0;
				1:       lim = '1;
				2:       lim = $urandom;
				default: lim = span * $urandom_range(1, 40);
				endcase
				ms_now += pick_delta();
				send(($urandom_range(0, 2) == 0) ? smc_pkg::REQ_BEGIN_SAFE : smc_pkg::REQ_BEGIN,
					aim, lim, ms_now);
				ticks = $urandom_range(1, 40);
				repeat (ticks) begin
					ms_now += pick_delta();
					if ($urandom_range(0, 19) == 0)
						send(($urandom_range(0, 1) == 0) ? smc_pkg::REQ_CLEAR
							: smc_pkg::REQ_BEGIN_SAFE, 16'($urandom), $urandom, ms_now);
					else
						send(smc_pkg::REQ_TICK, 16'($urandom), $urandom, ms_now);
				end
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0]  step_pick;
		logic [31:0] ivl_pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset register values
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'h0000_0000);
		send(smc_pkg::REQ_INIT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(smc_pkg::REQ_BEGIN, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'hFFFF_FFF5);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'h0000_0004);
		// zero budget times out on the next tick
		send(smc_pkg::REQ_BEGIN_SAFE, 16'hFFFE, 32'h0000_0000, 32'd200);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'd200);
		send(smc_pkg::REQ_BEGIN_SAFE, 16'h1234, 32'd1000, 32'd300);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'd320);
		send(smc_pkg::REQ_CLEAR, 16'hA5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
		// last step clamped, then reached
		send(smc_pkg::REQ_INIT, 16'd1000, 32'd0, 32'd0);
		send(smc_pkg::REQ_BEGIN, 16'd1001, 32'd1000, 32'd0);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'd19);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'd20);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'd40);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'd100);
		// downward motion, then budget runs out mid-move
		send(smc_pkg::REQ_BEGIN, 16'd0, 32'd50, 32'd1000);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'd1020);
		send(smc_pkg::REQ_TICK, 16'h0000, 32'h0000_0000, 32'd1050);
		send(smc_pkg::REQ_BEGIN, 16'd500, 32'hFFFF_FFFF, 32'd1060);
		for (int k = smc_pkg::REQ_INIT + 1; k < REQ_CODES; k++)
			send(3'(k), 16'($urandom), $urandom, $urandom);
		send(smc_pkg::REQ_INIT, 16'h0000, 32'h0000_0000, 32'h0000_0000);
		ms_now = 32'hFFFF_0000;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: begin
				step_pick = 8'd0;
				ivl_pick  = 32'd0;
			end
			1: begin
				step_pick = 8'd255;
				ivl_pick  = 32'hFFFF_FFFF;
			end
			2: begin
				step_pick = 8'd1;
				ivl_pick  = 32'd1;
			end
			3: begin
				step_pick = 8'($urandom_range(3, 254));
				ivl_pick  = $urandom_range(2, 200);
			end
			4: begin
				step_pick = 8'd255;
				ivl_pick  = 32'd5;
			end
			default: begin
				step_pick = smc_pkg::DEFAULT_STEP_SIZE;
				ivl_pick  = smc_pkg::DEFAULT_STEP_INTERVAL;
			end
			endcase
			write_reg(smc_pkg::CFG_STEP_SIZE, ($urandom & 32'hFFFF_FF00) | {24'd0, step_pick});
			write_reg(smc_pkg::CFG_STEP_INTERVAL, ivl_pick);
			drive_random(PHASE_ITEMS);
		end

		drain();
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
design/smc_pkg.sv
design/smc_cfg.sv
design/smc_core.sv
design/smc_out_reg.sv
design/servo_step_motion_controller.sv
tb/smc_motion_checker.sv
tb/tb.sv
